// ----- design/mhp_pkg.sv -----
// Package for the metaheader packet header parser.
// Holds the metaheader bit masks, verdict codes, register indexes and the layout helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhp_pkg;

  localparam logic [7:0] MK_CONT = 8'b1000_0000;
  localparam logic [7:0] MK_ESP  = 8'b0100_0000;
  localparam logic [7:0] MK_VER  = 8'b0010_0000;
  localparam logic [7:0] MK_ADDR = 8'b0001_1000;
  localparam logic [7:0] MK_A4   = 8'b0001_0000;
  localparam logic [7:0] MK_A2   = 8'b0000_1000;
  localparam logic [7:0] MK_TYPE = 8'b0000_0100;
  localparam logic [7:0] MK_TTL  = 8'b0000_0010;
  localparam logic [7:0] MK_FLOW = 8'b0000_0001;
  localparam logic [7:0] MK_SRC4 = 8'b0100_0000;
  localparam logic [7:0] MK_SRC2 = 8'b0010_0000;
  localparam logic [7:0] MK_LEN  = 8'b0001_0000;
  localparam logic [7:0] MK_CSUM = 8'b0000_1000;

  localparam logic [4:0] POS_MAX = 5'd31;

  typedef enum logic {
    CFG_LOCAL_ADDRESS    = 1'b0,
    CFG_EXPECTED_VERSION = 1'b1
  } cfg_index_e;

  typedef enum logic [3:0] {
    VD_ACCEPT    = 4'd0,
    VD_ESP       = 4'd1,
    VD_VERSION   = 4'd2,
    VD_DST16     = 4'd3,
    VD_DST2      = 4'd4,
    VD_DST_MISS  = 4'd5,
    VD_TTL       = 4'd6,
    VD_FLOW      = 4'd7,
    VD_SRC16     = 4'd8,
    VD_SRC2      = 4'd9,
    VD_THIRD     = 4'd10,
    VD_TRUNCATED = 4'd11
  } verdict_e;

  // Header layout, all sizes in bytes.
  typedef struct packed {
    logic [4:0] metas;
    logic [4:0] ver;
    logic [4:0] dst;
    logic [4:0] typ;
    logic [4:0] src;
    logic [4:0] len;
  } layout_t;

  // Parser state after the current byte is applied.
  typedef struct packed {
    logic [4:0]  pos;
    logic [7:0]  first_meta;
    logic [7:0]  second_meta;
    logic        ver_bad;
    logic [31:0] field_shift;
    logic [31:0] learned_source;
    logic [15:0] held_type;
    logic [15:0] held_length;
  } state_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] source_address;
    logic        source_learned;
    logic [15:0] type_value;
    logic        type_present;
    logic [15:0] length_value;
    logic        length_present;
    logic        checksum_flagged;
    logic [4:0]  payload_start;
  } result_t;

  function automatic layout_t mhp_layout(input logic [7:0] m1, input logic [7:0] m2_raw);
    layout_t    l;
    logic [7:0] m2;
    m2      = ((m1 & MK_CONT) != 8'd0) ? m2_raw : 8'd0;
    l.metas = 5'd1 + {4'd0, (m1 & MK_CONT) != 8'd0} + {4'd0, (m2 & MK_CONT) != 8'd0};
    l.ver   = ((m1 & MK_VER) != 8'd0) ? 5'd1 : 5'd0;
    l.dst   = ((m1 & MK_ADDR) == MK_A4) ? 5'd4 : 5'd0;
    l.typ   = ((m1 & MK_TYPE) != 8'd0) ? 5'd2 : 5'd0;
    l.src   = ((m2 & MK_SRC4) != 8'd0) ? 5'd4 : 5'd0;
    l.len   = ((m2 & MK_LEN) != 8'd0) ? 5'd2 : 5'd0;
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- design/mhp_capture.sv -----
// Header field capture: byte position, metaheaders and the field accumulators.
// Depends on mhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhp_capture (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_byte_i,
  input  wire logic [7:0]      expected_version_i,
  output mhp_pkg::state_t      state_o
);
  import mhp_pkg::*;

  logic [4:0]  pos_q, pos_d;
  logic [7:0]  m1_q, m1_d, m2_q, m2_d;
  logic        ver_bad_q, ver_bad_d;
  logic [31:0] dst_q, dst_d, src_q, src_d;
  logic [15:0] typ_q, typ_d, len_q, len_d;
  layout_t     lay;
  logic [4:0]  off, b_typ, b_src, b_len, b_end, k;
  logic        in_hdr;

  always_comb begin
    m1_d      = m1_q;
    m2_d      = m2_q;
    ver_bad_d = ver_bad_q;
    dst_d     = dst_q;
    src_d     = src_q;
    typ_d     = typ_q;
    len_d     = len_q;
    if (pos_q == 5'd0) begin
      m1_d      = data_byte_i;
      m2_d      = 8'd0;
      ver_bad_d = 1'b0;
      dst_d     = 32'd0;
      src_d     = 32'd0;
      typ_d     = 16'd0;
      len_d     = 16'd0;
    end else if (pos_q == 5'd1 && (m1_q & MK_CONT) != 8'd0) begin
      m2_d = data_byte_i;
    end

    lay    = mhp_layout(m1_d, m2_d);
    in_hdr = pos_q >= lay.metas;
    off    = pos_q - lay.metas;
    b_typ  = lay.ver + lay.dst;
    b_src  = b_typ + lay.typ;
    b_len  = b_src + lay.src;
    b_end  = b_len + lay.len;
    k      = 5'd0;

    if (in_hdr) begin
      if (lay.ver != 5'd0 && off == 5'd0) begin
        if (data_byte_i != expected_version_i) ver_bad_d = 1'b1;
      end else if (off >= lay.ver && off < b_typ) begin
        k = off - lay.ver;
        dst_d[{k[1:0], 3'b000} +: 8] = dst_d[{k[1:0], 3'b000} +: 8] | data_byte_i;
      end else if (off >= b_typ && off < b_src) begin
        k = off - b_typ;
        typ_d[{k[0], 3'b000} +: 8] = typ_d[{k[0], 3'b000} +: 8] | data_byte_i;
      end else if (off >= b_src && off < b_len) begin
        k = off - b_src;
        src_d[{k[1:0], 3'b000} +: 8] = src_d[{k[1:0], 3'b000} +: 8] | data_byte_i;
      end else if (off >= b_len && off < b_end) begin
        k = off - b_len;
        len_d[{k[0], 3'b000} +: 8] = len_d[{k[0], 3'b000} +: 8] | data_byte_i;
      end
    end

    if (last_byte_i) begin
      pos_d = 5'd0;
    end else if (pos_q == POS_MAX) begin
      pos_d = POS_MAX;
    end else begin
      pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 5'd0;
      m1_q      <= 8'd0;
      m2_q      <= 8'd0;
      ver_bad_q <= 1'b0;
      dst_q     <= 32'd0;
      src_q     <= 32'd0;
      typ_q     <= 16'd0;
      len_q     <= 16'd0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      m1_q      <= m1_d;
      m2_q      <= m2_d;
      ver_bad_q <= ver_bad_d;
      dst_q     <= dst_d;
      src_q     <= src_d;
      typ_q     <= typ_d;
      len_q     <= len_d;
    end
  end

  assign state_o.pos            = pos_q;
  assign state_o.first_meta     = m1_d;
  assign state_o.second_meta    = m2_d;
  assign state_o.ver_bad        = ver_bad_d;
  assign state_o.field_shift    = dst_d;
  assign state_o.learned_source = src_d;
  assign state_o.held_type      = typ_d;
  assign state_o.held_length    = len_d;

endmodule

`default_nettype wire

// ----- design/mhp_eval.sv -----
// Verdict logic: ordered header checks on the state that includes the last byte.
// Depends on mhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhp_eval (
  input  mhp_pkg::state_t  state_i,
  input  wire logic [31:0] local_address_i,
  output mhp_pkg::result_t result_o
);
  import mhp_pkg::*;

  layout_t    lay;
  logic [7:0] m1, m2;
  logic [5:0] n, need_m, need_ver, need_dst, need_typ, need_src, need_len;
  logic [5:0] hdr_len;
  verdict_e   v;
  logic       src_ok, typ_ok, len_ok, csum;

  always_comb begin
    m1       = state_i.first_meta;
    m2       = state_i.second_meta;
    lay      = mhp_layout(m1, m2);
    n        = {1'b0, state_i.pos} + 6'd1;
    need_m   = {1'b0, lay.metas};
    need_ver = need_m + {1'b0, lay.ver};
    need_dst = need_ver + {1'b0, lay.dst};
    need_typ = need_dst + {1'b0, lay.typ};
    need_src = need_typ + {1'b0, lay.src};
    need_len = need_src + {1'b0, lay.len};
    hdr_len  = need_len;
    v        = VD_ACCEPT;
    src_ok   = 1'b0;
    typ_ok   = 1'b0;
    len_ok   = 1'b0;
    csum     = 1'b0;

    if (n < need_m) begin
      v = VD_TRUNCATED;
    end else if ((m1 & MK_ESP) != 8'd0) begin
      v = VD_ESP;
    end else if (lay.ver != 5'd0 && n < need_ver) begin
      v = VD_TRUNCATED;
    end else if (lay.ver != 5'd0 && state_i.ver_bad) begin
      v = VD_VERSION;
    end else if ((m1 & MK_ADDR) == MK_ADDR) begin
      v = VD_DST16;
    end else if ((m1 & MK_A2) != 8'd0) begin
      v = VD_DST2;
    end else if (lay.dst != 5'd0 && n < need_dst) begin
      v = VD_TRUNCATED;
    end else if (lay.dst != 5'd0 && state_i.field_shift != local_address_i) begin
      v = VD_DST_MISS;
    end else if (lay.typ != 5'd0 && n < need_typ) begin
      v = VD_TRUNCATED;
    end else begin
      typ_ok = lay.typ != 5'd0;
      if ((m1 & MK_TTL) != 8'd0) begin
        v = VD_TTL;
      end else if ((m1 & MK_FLOW) != 8'd0) begin
        v = VD_FLOW;
      end else if ((m1 & MK_CONT) != 8'd0) begin
        if ((m2 & MK_ADDR) == MK_ADDR) begin
          v = VD_SRC16;
        end else if ((m2 & MK_SRC2) != 8'd0) begin
          v = VD_SRC2;
        end else if (lay.src != 5'd0 && n < need_src) begin
          v = VD_TRUNCATED;
        end else begin
          src_ok = lay.src != 5'd0;
          if (lay.len != 5'd0 && n < need_len) begin
            v = VD_TRUNCATED;
          end else begin
            len_ok = lay.len != 5'd0;
            csum   = (m2 & MK_CSUM) != 8'd0;
            if ((m2 & MK_CONT) != 8'd0) v = VD_THIRD;
          end
        end
      end
    end

    result_o.verdict          = v;
    result_o.source_address   = src_ok ? state_i.learned_source : 32'd0;
    result_o.source_learned   = src_ok;
    result_o.type_value       = typ_ok ? state_i.held_type : 16'd0;
    result_o.type_present     = typ_ok;
    result_o.length_value     = len_ok ? state_i.held_length : 16'd0;
    result_o.length_present   = len_ok;
    result_o.checksum_flagged = csum;
    result_o.payload_start    = (v == VD_ACCEPT) ? hdr_len[4:0] : 5'd0;
  end

endmodule

`default_nettype wire

// ----- design/metaheader_packet_header_parser_core.sv -----
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i/in_stall_o  | data_byte_i, last_byte_i
// result   | out       | out_valid_o/out_stall_i| verdict_o .. payload_start_o
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per cycle, except while a last byte is stalled. A result appears in the cycle after its last byte.
// Each byte updates the header state in the cycle it is accepted; the
// verdict is computed from that state and loaded into the result register.
// Reset clears the byte position, header state and the result register.
// While a result is held by out_stall_i, non-last bytes are still taken.
// Depends on mhp_pkg, mhp_capture, mhp_eval.
`timescale 1ns / 1ps
`default_nettype none

module metaheader_packet_header_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       verdict_o,
  output logic [31:0]      source_address_o,
  output logic             source_learned_o,
  output logic [15:0]      type_value_o,
  output logic             type_present_o,
  output logic [15:0]      length_value_o,
  output logic             length_present_o,
  output logic             checksum_flagged_o,
  output logic [4:0]       payload_start_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import mhp_pkg::*;

  logic        accept;
  logic        out_valid_q, out_valid_d;
  logic [31:0] local_address_q;
  logic [7:0]  expected_version_q;
  state_t      state;
  result_t     result_d, result_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i & last_byte_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_address_q    <= 32'd0;
      expected_version_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LOCAL_ADDRESS:    local_address_q    <= cfg_data_i;
        CFG_EXPECTED_VERSION: expected_version_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mhp_capture u_capture (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .expected_version_i (expected_version_q),
    .state_o            (state)
  );

  mhp_eval u_eval (
    .state_i         (state),
    .local_address_i (local_address_q),
    .result_o        (result_d)
  );

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (accept && last_byte_i) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
    end else if (accept && last_byte_i) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign verdict_o          = result_q.verdict;
  assign source_address_o   = result_q.source_address;
  assign source_learned_o   = result_q.source_learned;
  assign type_value_o       = result_q.type_value;
  assign type_present_o     = result_q.type_present;
  assign length_value_o     = result_q.length_value;
  assign length_present_o   = result_q.length_present;
  assign checksum_flagged_o = result_q.checksum_flagged;
  assign payload_start_o    = result_q.payload_start;

endmodule

`default_nettype wire

// ----- design/mhp_checker.sv -----
// Port-level checks for the metaheader packet header parser, bound to the top level.
// Depends on mhp_pkg and metaheader_packet_header_parser_core.
`timescale 1ns / 1ps
`default_nettype none

module mhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  verdict_o,
  input wire logic [31:0] source_address_o,
  input wire logic        source_learned_o,
  input wire logic [15:0] type_value_o,
  input wire logic        type_present_o,
  input wire logic [4:0]  payload_start_o
);
  import mhp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o)
      && $stable(source_address_o))
    else $error("result changed while stalled");

  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o <= VD_TRUNCATED)
    else $error("verdict out of range");

  a_offset_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != VD_ACCEPT |-> payload_start_o == 5'd0)
    else $error("payload offset on dropped item");

  a_offset_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VD_ACCEPT |-> payload_start_o >= 5'd1 && payload_start_o <= 5'd16)
    else $error("payload offset out of range");

  a_source_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !source_learned_o && !type_present_o |->
      source_address_o == 32'd0 && type_value_o == 16'd0)
    else $error("field value without present flag");

endmodule

bind metaheader_packet_header_parser_core mhp_checker u_mhp_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for metaheader_packet_header_parser_core: sends directed and random packets byte
// by byte and predicts each verdict in a scoreboard, checked field by field.
// Depends on mhp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mhp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_BYTES = 500;
  localparam int HOLD_CYCLES = 400;

  class verdict_scoreboard;
    logic [31:0] local_addr;
    logic [7:0]  want_ver;
    logic [4:0]  pos;
    logic [7:0]  meta1;
    logic [7:0]  meta2;
    logic        ver_bad;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    logic [15:0] type_val;
    logic [15:0] len_val;
    result_t     expected_verdicts[$];
    int          errors;

    function new();
      local_addr = '0;
      want_ver = 8'd1;
      pos = '0;
      meta1 = '0;
      meta2 = '0;
      ver_bad = 1'b0;
      dst_addr = '0;
      src_addr = '0;
      type_val = '0;
      len_val = '0;
      errors = 0;
    endfunction

    function void absorb_byte(logic [7:0] b, logic last);
      int         p, n, metas, nver, ndst, ntyp, nsrc, nlen, off, need;
      logic [7:0] m2;
      logic       src_ok, typ_ok, len_ok, csum;
      verdict_e   v;
      result_t    r;
      p = pos;
      if (p == 0) begin
        meta1 = b;
        meta2 = '0;
        ver_bad = 1'b0;
        dst_addr = '0;
        src_addr = '0;
        type_val = '0;
        len_val = '0;
      end else if (p == 1 && meta1[7]) begin
        meta2 = b;
      end
      m2 = meta1[7] ? meta2 : 8'h00;
      metas = 1 + int'(meta1[7]) + int'(m2[7]);
      nver = meta1[5] ? 1 : 0;
      ndst = (meta1[4:3] == 2'b10) ? 4 : 0;
      ntyp = meta1[2] ? 2 : 0;
      nsrc = m2[6] ? 4 : 0;
      nlen = m2[4] ? 2 : 0;
      if (p >= metas) begin
        off = p - metas;
        if (nver != 0 && off == 0) begin
          if (b != want_ver) ver_bad = 1'b1;
        end else if (off >= nver && off < nver + ndst) begin
          dst_addr[8*(off-nver) +: 8] = b;
        end else if (off >= nver + ndst && off < nver + ndst + ntyp) begin
          type_val[8*(off-nver-ndst) +: 8] = b;
        end else if (off >= nver + ndst + ntyp && off < nver + ndst + ntyp + nsrc) begin
          src_addr[8*(off-nver-ndst-ntyp) +: 8] = b;
        end else if (off >= nver + ndst + ntyp + nsrc &&
                     off < nver + ndst + ntyp + nsrc + nlen) begin
          len_val[8*(off-nver-ndst-ntyp-nsrc) +: 8] = b;
        end
      end
      if (!last) begin
        pos = (p < 31) ? 5'(p + 1) : 5'd31;
        return;
      end

      n = p + 1;
      need = metas;
      src_ok = 1'b0;
      typ_ok = 1'b0;
      len_ok = 1'b0;
      csum = 1'b0;
      if (n < need) v = VD_TRUNCATED;
      else if (meta1[6]) v = VD_ESP;
      else if (nver != 0 && n < need + 1) v = VD_TRUNCATED;
      else if (nver != 0 && ver_bad) v = VD_VERSION;
      else begin
        need += nver;
        if (meta1[4:3] == 2'b11) v = VD_DST16;
        else if (meta1[3]) v = VD_DST2;
        else if (meta1[4] && n < need + 4) v = VD_TRUNCATED;
        else if (meta1[4] && dst_addr != local_addr) v = VD_DST_MISS;
        else begin
          need += ndst;
          if (ntyp != 0 && n < need + 2) v = VD_TRUNCATED;
          else begin
            need += ntyp;
            typ_ok = (ntyp != 0);
            if (meta1[1]) v = VD_TTL;
            else if (meta1[0]) v = VD_FLOW;
            else if (!meta1[7]) v = VD_ACCEPT;
            else if (meta2[4:3] == 2'b11) v = VD_SRC16;
            else if (meta2[5]) v = VD_SRC2;
            else if (nsrc != 0 && n < need + 4) v = VD_TRUNCATED;
            else begin
              need += nsrc;
              src_ok = (nsrc != 0);
              if (nlen != 0 && n < need + 2) v = VD_TRUNCATED;
              else begin
                len_ok = (nlen != 0);
                csum = meta2[3];
                v = meta2[7] ? VD_THIRD : VD_ACCEPT;
              end
            end
          end
        end
      end

      r.verdict = v;
      r.source_address = src_ok ? src_addr : 32'd0;
      r.source_learned = src_ok;
      r.type_value = typ_ok ? type_val : 16'd0;
      r.type_present = typ_ok;
      r.length_value = len_ok ? len_val : 16'd0;
      r.length_present = len_ok;
      r.checksum_flagged = csum;
      r.payload_start = (v == VD_ACCEPT) ? 5'(metas + nver + ndst + ntyp + nsrc + nlen) : 5'd0;
      expected_verdicts.push_back(r);
      pos = '0;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_verdicts.size() == 0) begin
        $error("result with no packet pending: verdict %0d", got.verdict);
        errors++;
        return;
      end
      exp = expected_verdicts.pop_front();
      if (got.verdict != exp.verdict) begin
        $error("verdict: expected %0d, got %0d", exp.verdict, got.verdict);
        errors++;
      end
      if (got.source_address != exp.source_address) begin
        $error("source_address: expected %h, got %h", exp.source_address, got.source_address);
        errors++;
      end
      if (got.source_learned != exp.source_learned) begin
        $error("source_learned: expected %0d, got %0d", exp.source_learned, got.source_learned);
        errors++;
      end
      if (got.type_value != exp.type_value) begin
        $error("type_value: expected %h, got %h", exp.type_value, got.type_value);
        errors++;
      end
      if (got.type_present != exp.type_present) begin
        $error("type_present: expected %0d, got %0d", exp.type_present, got.type_present);
        errors++;
      end
      if (got.length_value != exp.length_value) begin
        $error("length_value: expected %h, got %h", exp.length_value, got.length_value);
        errors++;
      end
      if (got.length_present != exp.length_present) begin
        $error("length_present: expected %0d, got %0d", exp.length_present, got.length_present);
        errors++;
      end
      if (got.checksum_flagged != exp.checksum_flagged) begin
        $error("checksum_flagged: expected %0d, got %0d", exp.checksum_flagged,
               got.checksum_flagged);
        errors++;
      end
      if (got.payload_start != exp.payload_start) begin
        $error("payload_start: expected %0d, got %0d", exp.payload_start, got.payload_start);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  verdict_o;
  logic [31:0] source_address_o;
  logic        source_learned_o;
  logic [15:0] type_value_o;
  logic        type_present_o;
  logic [15:0] length_value_o;
  logic        length_present_o;
  logic        checksum_flagged_o;
  logic [4:0]  payload_start_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_index_e  cfg_index_i = CFG_LOCAL_ADDRESS;
  logic [31:0] cfg_data_i = 32'd0;

  verdict_scoreboard sb = new();
  logic [7:0]        pkt[$];
  int                burst_left = 0;
  int                idle_cycles = 0;
  logic              pressure_go = 1'b0;

  always #5 clk_i = ~clk_i;

  metaheader_packet_header_parser_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .verdict_o          (verdict_o),
    .source_address_o   (source_address_o),
    .source_learned_o   (source_learned_o),
    .type_value_o       (type_value_o),
    .type_present_o     (type_present_o),
    .length_value_o     (length_value_o),
    .length_present_o   (length_present_o),
    .checksum_flagged_o (checksum_flagged_o),
    .payload_start_o    (payload_start_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  task automatic send_packet();
    int i;
    for (i = 0; i < pkt.size(); i++) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
                     $urandom_range(1, 20);
      end
      in_valid_i <= 1'b1;
      data_byte_i <= pkt[i];
      last_byte_i <= (i == pkt.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
      sb.absorb_byte(pkt[i], i == pkt.size() - 1);
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(logic [31:0] addr, logic [7:0] ver);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LOCAL_ADDRESS;
    cfg_data_i <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.local_addr = addr;
    cfg_index_i <= CFG_EXPECTED_VERSION;
    cfg_data_i <= {24'd0, ver};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.want_ver = ver;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed headers with random content, some noise and cut-short packets.
  task automatic build_packet();
    logic [7:0] m1, m2;
    int         n, i;
    pkt = {};
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) pkt.push_back(8'($urandom));
      return;
    end
    m1 = 8'($urandom);
    m2 = 8'($urandom);
    m1[6] = ($urandom_range(0, 15) == 0);
    m1[1] = ($urandom_range(0, 7) == 0);
    m1[0] = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 7) != 0) m1[4:3] = $urandom_range(0, 1) ? 2'b10 : 2'b00;
    m2[5] = ($urandom_range(0, 9) == 0);
    if (m2[4:3] == 2'b11 && $urandom_range(0, 7) != 0) m2[3] = 1'b0;
    m2[7] = ($urandom_range(0, 5) == 0);
    pkt.push_back(m1);
    if (m1[7]) pkt.push_back(m2);
    if (m1[7] && m2[7]) pkt.push_back(8'($urandom));
    if (m1[5]) pkt.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : sb.want_ver);
    if (m1[4:3] == 2'b10) begin
      for (i = 0; i < 4; i++) begin
        pkt.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : sb.local_addr[8*i +: 8]);
      end
    end
    if (m1[2]) repeat (2) pkt.push_back(8'($urandom));
    if (m1[7] && m2[6]) repeat (4) pkt.push_back(8'($urandom));
    if (m1[7] && m2[4]) repeat (2) pkt.push_back(8'($urandom));
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 36) : $urandom_range(0, 4);
    repeat (n) pkt.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, pkt.size());
      while (pkt.size() > n) void'(pkt.pop_back());
    end
  endtask

  initial begin
    int mode, span;
    logic held;
    result_t got;
    span = 0;
    mode = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (pressure_go && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 300);
      end
      out_stall_i <= (mode == 0) ? 1'b0 :
                     (mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.verdict = verdict_e'(verdict_o);
        got.source_address = source_address_o;
        got.source_learned = source_learned_o;
        got.type_value = type_value_o;
        got.type_present = type_present_o;
        got.length_value = length_value_o;
        got.length_present = length_present_o;
        got.checksum_flagged = checksum_flagged_o;
        got.payload_start = payload_start_o;
        sb.check_result(got);
      end
      span--;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int ph, sent;
    logic [31:0] addr;
    logic [7:0]  ver;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pkt = '{8'h00}; send_packet();
    pkt = '{8'h40}; send_packet();
    pkt = '{8'h20, 8'h02}; send_packet();
    pkt = '{8'h18}; send_packet();
    pkt = '{8'h08}; send_packet();
    pkt = '{8'h10, 8'h01, 8'h00, 8'h00, 8'h00}; send_packet();
    pkt = '{8'h02}; send_packet();
    pkt = '{8'h01}; send_packet();
    pkt = '{8'h80, 8'h18}; send_packet();
    pkt = '{8'h80, 8'h20}; send_packet();
    pkt = '{8'h80, 8'h80, 8'h00}; send_packet();
    pkt = '{8'h80, 8'h08}; send_packet();
    pkt = '{8'hFF}; send_packet();
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          addr = 32'hFFFF_FFFF;
          ver = 8'hFF;
        end
        1: begin
          addr = 32'd0;
          ver = 8'h00;
        end
        2: begin
          addr = $urandom;
          ver = 8'($urandom);
        end
        default: begin
          addr = $urandom;
          ver = 8'd1;
        end
      endcase
      load_settings(addr, ver);
      if (ph == 0) pressure_go = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_packet();
        send_packet();
        sent += pkt.size();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mhp_pkg.sv
design/mhp_capture.sv
design/mhp_eval.sv
design/metaheader_packet_header_parser_core.sv
design/mhp_checker.sv
tb/tb.sv
